[design/ibus_frame_decoder_assert.svh]
// Assertion macros shared by the decoder RTL.
// IBF_ASSERT checks out of reset only; IBF_ASSERT_ALWAYS checks on every edge.
`ifndef IBUS_FRAME_DECODER_ASSERT_SVH
`define IBUS_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define IBF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IBF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IBF_ASSERT(label, prop, msg)
`define IBF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[design/ibf_pkg.sv]
package ibf_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int MAX_CHANNELS = 14;

    localparam logic [3:0]       CFG_RESET     = 4'd10;
    localparam logic [15:0]      SUM_START     = 16'hFFFF;
    localparam logic [7:0]       HEADER_FIRST  = 8'd32;
    localparam logic [7:0]       HEADER_SECOND = 8'd64;
    localparam logic [POS_W-1:0] SUM_LAST_POS  = POS_W'(29);
    localparam logic [POS_W-1:0] CHECK_LO_POS  = POS_W'(30);
    localparam logic [POS_W-1:0] LAST_POS      = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CH_BASE_POS   = POS_W'(2);

    // result status codes
    localparam logic [1:0] ST_CHANNEL    = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_BAD_SUM    = 2'd2;

    // control of the shared checksum subtractor
    typedef struct packed {
        logic from_start;  // minuend is the start value, not the running sum
        logic update;      // load the difference into the running sum
        logic clear;       // reload the start value
    } t_csum_ctrl;

endpackage

[design/ibf_ram.sv]
module ibf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/ibf_csum.sv]
module ibf_csum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ibf_pkg::t_csum_ctrl i_ctrl,
    input  logic [15:0]        i_operand,
    output logic               o_zero
);
    import ibf_pkg::*;

    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [15:0] w_minuend;
    logic [15:0] w_diff;

    // one subtractor: accumulates bytes, and compares against the frame checksum
    assign w_minuend = i_ctrl.from_start ? SUM_START : r_sum;
    assign w_diff    = w_minuend - i_operand;
    assign o_zero    = (w_diff == 16'd0);

    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.update) begin
            n_sum = w_diff;
        end else if (i_ctrl.clear) begin
            n_sum = SUM_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_START;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

[design/ibus_frame_decoder.sv]
// iBus frame decoder. Received bytes arrive one per transaction on the slave
// stream, with tuser marking byte 0 of a frame (it forces the byte position
// back to 0 and restarts the checksum). Bytes are kept in a 32-entry frame
// RAM while one shared 16-bit subtractor keeps the running checksum
// (65535 minus bytes 0 to 29). Each byte is taken in the accept state and
// then stored and accumulated in the byte state, after which tready returns.
// Byte 31 adds a check state, where the same subtractor compares the sum with
// bytes 30/31 and the header (32, 64) is tested. A bad frame gives one status
// transaction with tlast set; a good frame gives one transaction per channel
// in use (1 to 14, clamped from the configuration register, reset 10), the
// last one with tlast. Each channel is read out through S_RD_LO, S_RD_HI and
// S_EMIT, since each channel word takes two reads through the single RAM read
// port, and waits in S_EMIT on any master-side stall; the slave side is not
// ready during readout. The output register lets the next byte be accepted
// while the final result waits. The frame RAM needs no clearing after reset.
`include "ibus_frame_decoder_assert.svh"
module ibus_frame_decoder #(
    parameter int CHANNELS_MAX = ibf_pkg::MAX_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: channels_in_use
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] status, [5:2] channel_index,
                                        // [21:6] channel_value, [23:22] zero
    output logic        m_axis_tlast    // last
);
    import ibf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_CHECK,
        S_ERR,
        S_RD_LO,
        S_RD_HI,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_byte, n_byte;
    logic             r_start, n_start;
    logic [7:0]       r_hdr0, n_hdr0;
    logic [7:0]       r_hdr1, n_hdr1;
    logic [7:0]       r_chk_lo, n_chk_lo;
    logic [7:0]       r_lo_byte, n_lo_byte;
    logic [1:0]       r_err, n_err;
    logic [3:0]       r_ch, n_ch;
    logic [3:0]       r_cfg;
    logic             r_out_valid, n_out_valid;
    logic [23:0]      r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic [POS_W-1:0] w_pos;
    logic [POS_W-1:0] w_lo_addr;
    logic [POS_W-1:0] w_raddr;
    logic [7:0]       w_rdata;
    logic             w_we;
    logic             w_out_free;
    logic             w_zero;
    logic [3:0]       w_n_eff;
    logic [15:0]      w_operand;
    t_csum_ctrl       w_ctrl;

    // effective position of the byte being stored
    assign w_pos      = r_start ? '0 : r_pos;
    assign w_lo_addr  = {r_ch, 1'b0} + CH_BASE_POS;
    assign w_raddr    = (r_state == S_RD_LO) ? w_lo_addr : w_lo_addr + POS_W'(1);
    assign w_we       = (r_state == S_BYTE);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // clamp channels_in_use to 1..CHANNELS_MAX
    always_comb begin
        if (r_cfg == 4'd0) begin
            w_n_eff = 4'd1;
        end else if (r_cfg > 4'(CHANNELS_MAX)) begin
            w_n_eff = 4'(CHANNELS_MAX);
        end else begin
            w_n_eff = r_cfg;
        end
    end

    // subtractor control: accumulate in S_BYTE, compare then clear in S_CHECK
    always_comb begin
        w_ctrl    = '0;
        w_operand = {8'd0, r_byte};
        if (r_state == S_BYTE) begin
            w_ctrl.from_start = r_start;
            w_ctrl.update     = (w_pos <= SUM_LAST_POS);
            w_ctrl.clear      = r_start;
        end else if (r_state == S_CHECK) begin
            w_operand    = {r_byte, r_chk_lo};
            w_ctrl.clear = 1'b1;
        end
    end

    ibf_csum u_csum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_operand(w_operand),
        .o_zero   (w_zero)
    );

    ibf_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES)
    ) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_pos),
        .i_wdata(r_byte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_byte      = r_byte;
        n_start     = r_start;
        n_hdr0      = r_hdr0;
        n_hdr1      = r_hdr1;
        n_chk_lo    = r_chk_lo;
        n_lo_byte   = r_lo_byte;
        n_err       = r_err;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_byte  = s_axis_tdata;
                    n_start = s_axis_tuser[0];
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (w_pos == '0)          n_hdr0   = r_byte;
                if (w_pos == POS_W'(1))   n_hdr1   = r_byte;
                if (w_pos == CHECK_LO_POS) n_chk_lo = r_byte;
                n_start = 1'b0;
                if (w_pos == LAST_POS) begin
                    n_pos   = w_pos;
                    n_state = S_CHECK;
                end else begin
                    n_pos   = w_pos + POS_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                // header test has priority over the checksum test
                n_pos = '0;
                n_ch  = 4'd0;
                if (r_hdr0 != HEADER_FIRST || r_hdr1 != HEADER_SECOND) begin
                    n_err   = ST_BAD_HEADER;
                    n_state = S_ERR;
                end else if (!w_zero) begin
                    n_err   = ST_BAD_SUM;
                    n_state = S_ERR;
                end else begin
                    n_state = S_RD_LO;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, 16'd0, 4'd0, r_err};
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD_LO: begin
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                n_lo_byte = w_rdata;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // read address holds on the high byte while the output stalls
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, w_rdata, r_lo_byte, r_ch, ST_CHANNEL};
                    n_out_last  = (r_ch == w_n_eff - 4'd1);
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + 4'd1;
                        n_state = S_RD_LO;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_start     <= 1'b0;
            r_ch        <= 4'd0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
        end
        r_byte     <= n_byte;
        r_hdr0     <= n_hdr0;
        r_hdr1     <= n_hdr1;
        r_chk_lo   <= n_chk_lo;
        r_lo_byte  <= n_lo_byte;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `IBF_ASSERT(a_err_is_last, r_out_valid && r_out_data[1:0] != ST_CHANNEL |-> r_out_last, "error result without last")
    `IBF_ASSERT(a_check_at_end, r_state == S_CHECK |-> r_pos == LAST_POS, "frame check away from last byte")
    `IBF_ASSERT(a_ch_in_range, r_state == S_EMIT |-> r_ch < w_n_eff, "channel index past channels in use")
    `IBF_ASSERT(a_accept_to_store, s_axis_tvalid && s_axis_tready |=> r_state == S_BYTE, "accepted byte not stored")

endmodule

[verif/ibus_frame_decoder_test.sv]
module ibus_frame_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ibf_pkg::*;

    // cycles allowed for the block to finish a byte and drain its output
    // register once the last expected transaction has been seen
    localparam int SETTLE_CYCLES = 16;
    // long receiver hold-off used to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // bytes offered per random phase, at least
    localparam int PHASE_BYTES = 20;

    typedef logic [7:0] t_frame [FRAME_BYTES];

    // one output transaction, split into its fields
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } t_chan_result;

    typedef enum int {FRM_GOOD, FRM_BAD_HEADER, FRM_BAD_SUM, FRM_BAD_BOTH} t_frame_kind;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill_kind;

    // Tracks the decoder: byte position, running checksum, frame bytes and the
    // channel count. Every accepted byte is folded in; a completed frame pushes
    // the transactions the block owes onto results_due.
    class t_ibus_frame_scoreboard;
        logic [7:0]       frame_bytes [FRAME_BYTES];
        logic [POS_W-1:0] byte_pos;
        logic [15:0]      csum;
        logic [3:0]       channels_cfg;
        t_chan_result     results_due [$];
        int unsigned      predicted;
        int unsigned      errors;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            byte_pos     = '0;
            csum         = SUM_START;
            channels_cfg = CFG_RESET;
            predicted    = 0;
            errors       = 0;
        endfunction

        function void set_channels(logic [3:0] chans);
            channels_cfg = chans;
        endfunction

        function void note_byte(logic [7:0] rx, logic sof);
            t_chan_result     r;
            int unsigned      n;
            logic [POS_W-1:0] lo;
            if (sof) begin
                byte_pos = '0;
                csum     = SUM_START;
            end
            frame_bytes[byte_pos] = rx;
            if (byte_pos <= SUM_LAST_POS) begin
                csum = csum - rx;
            end
            if (byte_pos != LAST_POS) begin
                byte_pos = byte_pos + 1'b1;
                return;
            end
            // frame end: header test wins over checksum test
            byte_pos = '0;
            r        = '0;
            r.last   = 1'b1;
            if (frame_bytes[0] != HEADER_FIRST || frame_bytes[1] != HEADER_SECOND) begin
                r.status = ST_BAD_HEADER;
                results_due.push_back(r);
                predicted++;
            end else if (csum != {frame_bytes[CHECK_LO_POS + 1'b1],
                                  frame_bytes[CHECK_LO_POS]}) begin
                r.status = ST_BAD_SUM;
                results_due.push_back(r);
                predicted++;
            end else begin
                // out-of-range counts clamp to 1..MAX_CHANNELS
                n = channels_cfg;
                if (n < 1) n = 1;
                if (n > MAX_CHANNELS) n = MAX_CHANNELS;
                for (int ch = 0; ch < n; ch++) begin
                    lo       = CH_BASE_POS + POS_W'(2 * ch);
                    r.status = ST_CHANNEL;
                    r.index  = 4'(ch);
                    r.value  = {frame_bytes[lo + 1'b1], frame_bytes[lo]};
                    r.last   = (ch + 1 == n);
                    results_due.push_back(r);
                    predicted++;
                end
            end
            csum = SUM_START;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_chan_result got);
            t_chan_result want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction st=%0d idx=%0d val=%h last=%b",
                                          got.status, got.index, got.value, got.last));
                return;
            end
            want = results_due.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.index != want.index)
                report_mismatch($sformatf("channel_index %0d, want %0d", got.index, want.index));
            if (got.value != want.value)
                report_mismatch($sformatf("channel_value %h, want %h", got.value, want.value));
            if (got.last != want.last)
                report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic [0:0]  s_axis_tuser;    // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [1:0] status, [5:2] index, [21:6] value
    logic        m_axis_tlast;

    t_ibus_frame_scoreboard board = new();

    int unsigned src_idle_pct   = 0;   // chance of a gap before each byte
    int unsigned sink_stall_pct = 0;   // chance of tready low per cycle
    int unsigned rx_hold_cycles = 0;   // pending receiver hold-off
    int unsigned bytes_sent     = 0;

    ibus_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Output monitor: values seen here are the ones present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result('{status: m_axis_tdata[1:0],
                                 index:  m_axis_tdata[5:2],
                                 value:  m_axis_tdata[21:6],
                                 last:   m_axis_tlast});
        end
    end

    // Offers one byte and returns at the edge where it was taken. tvalid stays
    // high on return so back-to-back bytes need no extra cycle.
    task automatic send_byte(logic [7:0] rx, logic sof);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_byte(rx, sof);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // First nbytes of a frame; the start flag, if asked for, rides on byte 0.
    task automatic send_frame(t_frame f, int nbytes, logic with_sof);
        for (int i = 0; i < nbytes; i++) begin
            send_byte(f[i], with_sof && (i == 0));
        end
    endtask

    // Waits until every owed transaction is out, plus settle time for the
    // last byte and the output register.
    task automatic wait_idle();
        while (board.results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_channels(logic [3:0] chans);
        stop_sending();
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= chans;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_channels(chans);
    endtask

    // Builds a frame with header, channel payload and a checksum that is
    // right unless the kind asks for it to be broken.
    function automatic void make_frame(output t_frame f, input t_frame_kind kind,
                                       input t_fill_kind fill);
        logic [15:0] sum;
        f[0] = HEADER_FIRST;
        f[1] = HEADER_SECOND;
        for (int i = 2; i < FRAME_BYTES; i++) begin
            case (fill)
                FILL_ZERO: f[i] = 8'h00;
                FILL_ONES: f[i] = 8'hFF;
                default:   f[i] = 8'($urandom_range(255));
            endcase
        end
        if (kind == FRM_BAD_HEADER || kind == FRM_BAD_BOTH) begin
            case ($urandom_range(2))
                0: f[0] = f[0] ^ 8'($urandom_range(1, 255));
                1: f[1] = f[1] ^ 8'($urandom_range(1, 255));
                default: begin
                    f[0] = f[0] ^ 8'($urandom_range(1, 255));
                    f[1] = f[1] ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        sum = SUM_START;
        for (int i = 0; i <= int'(SUM_LAST_POS); i++) sum = sum - f[i];
        if (kind == FRM_BAD_SUM || kind == FRM_BAD_BOTH) begin
            sum = sum ^ 16'($urandom_range(1, 65535));
        end
        f[CHECK_LO_POS]        = sum[7:0];
        f[CHECK_LO_POS + 1'b1] = sum[15:8];
    endfunction

    // Mostly well-formed frames with random payload; the rest are bad frames,
    // truncated frames and raw noise with stray start flags.
    task automatic run_random_phase(int unsigned src_pct, int unsigned sink_pct,
                                    logic [3:0] chans);
        t_frame      f;
        int unsigned first_byte;
        int unsigned pick;
        t_fill_kind  fill;
        write_channels(chans);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        first_byte     = bytes_sent;
        while (bytes_sent - first_byte < PHASE_BYTES) begin
            pick = $urandom_range(99);
            case ($urandom_range(9))
                0:       fill = FILL_ZERO;
                1:       fill = FILL_ONES;
                default: fill = FILL_RANDOM;
            endcase
            if (pick < 60) begin
                make_frame(f, FRM_GOOD, fill);
                send_frame(f, FRAME_BYTES, $urandom_range(9) != 0);
            end else if (pick < 70) begin
                make_frame(f, FRM_BAD_HEADER, fill);
                send_frame(f, FRAME_BYTES, 1'b1);
            end else if (pick < 80) begin
                make_frame(f, FRM_BAD_SUM, fill);
                send_frame(f, FRAME_BYTES, 1'b1);
            end else if (pick < 85) begin
                make_frame(f, FRM_BAD_BOTH, fill);
                send_frame(f, FRAME_BYTES, 1'b1);
            end else if (pick < 93) begin
                make_frame(f, FRM_GOOD, fill);
                send_frame(f, $urandom_range(1, FRAME_BYTES - 1), 1'b1);
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                end
            end
        end
        stop_sending();
    endtask

    initial begin
        t_frame f;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. Reset channel count first, and a frame
        // with no start flag: the position is already 0 out of reset.
        make_frame(f, FRM_GOOD, FILL_RANDOM);
        send_frame(f, FRAME_BYTES, 1'b0);
        // bad header and bad checksum together: header status must win
        make_frame(f, FRM_BAD_BOTH, FILL_RANDOM);
        send_frame(f, FRAME_BYTES, 1'b1);
        stop_sending();

        // Random part under each idling pattern; the first phase uses the
        // channel code 0, which clamps to one channel.
        run_random_phase(0, 0, 4'd0);
        run_random_phase(77, 0, 4'($urandom_range(15)));
        run_random_phase(0, 77, 4'($urandom_range(15)));
        run_random_phase(7, 7, 4'($urandom_range(15)));

        // Back-pressure: receiver holds off while a full frame and the start
        // of the next keep coming, so the output register fills and the input
        // side stalls. Code 15 clamps to the maximum channel count.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_channels(4'd15);
        rx_hold_cycles = HOLD_OFF_CYCLES;
        make_frame(f, FRM_GOOD, FILL_ONES);
        send_frame(f, FRAME_BYTES, 1'b1);
        make_frame(f, FRM_GOOD, FILL_RANDOM);
        send_frame(f, 2, 1'b1);
        stop_sending();

        wait_idle();
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
